[rtl/core/bas_pkg.sv]
// ----------------------------------------------------------------------------
// bas_pkg: shared types and codes for the bounded array stack
// Opcodes, status codes, fixed field widths and the cell control word.
// ----------------------------------------------------------------------------
package bas_pkg;

   // fixed field widths
   localparam int OP_W   = 3;
   localparam int WORD_W = 32;   // width of push_value and data on the ports
   localparam int POS_W  = 7;
   localparam int CAP_W  = 7;
   localparam int TOT_W  = 7;
   localparam int ST_W   = 2;

   // opcodes
   localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
   localparam logic [OP_W-1:0] OP_POP   = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
   localparam logic [OP_W-1:0] OP_TOP   = 3'd3;
   localparam logic [OP_W-1:0] OP_DRAIN = 3'd4;

   // status codes
   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [ST_W-1:0] ST_BADPOS    = 2'd3;

   // register file
   localparam int               CSR_ADDR_W   = 3;
   localparam int               CSR_DATA_W   = 32;
   localparam logic             REG_CAPACITY = 1'b0;  // register index, paddr[2]
   localparam logic [CAP_W-1:0] CAP_RESET    = 7'd64;

   // shift command broadcast along the cell row
   typedef struct packed {
      logic push;   // every cell takes its upper neighbour's word
      logic pop;    // every cell takes its lower neighbour's word
   } shift_type;

endpackage

[rtl/core/bas_cell.sv]
// ----------------------------------------------------------------------------
// bas_cell: one stack entry
// Holds one word; shifts down on push, up on pop, gates its word onto the
// peek bus when selected.
// ----------------------------------------------------------------------------
module bas_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  bas_pkg::shift_type    ctrl,
   input  logic [DATA_WIDTH-1:0] above_word,
   input  logic [DATA_WIDTH-1:0] below_word,
   input  logic                  select,
   output logic [DATA_WIDTH-1:0] word,
   output logic [DATA_WIDTH-1:0] tap_word
);
   import bas_pkg::*;

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctrl.push) begin
         word_in = above_word;
      end else if (ctrl.pop) begin
         word_in = below_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word     = word_ff;
   assign tap_word = select ? word_ff : '0;

endmodule

[rtl/core/bas_cell_chain.sv]
// ----------------------------------------------------------------------------
// bas_cell_chain: row of stack cells
// Cell 0 is the top of the stack; cell i holds the word at depth i+1.
// ----------------------------------------------------------------------------
module bas_cell_chain #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  bas_pkg::shift_type       ctrl,
   input  logic [DATA_WIDTH-1:0]    push_word,
   input  logic [bas_pkg::POS_W-1:0] peek_pos,
   output logic [DATA_WIDTH-1:0]    top_word,
   output logic [DATA_WIDTH-1:0]    peek_word
);
   import bas_pkg::*;

   logic [DATA_WIDTH-1:0] words [DEPTH];
   logic [DATA_WIDTH-1:0] taps  [DEPTH];
   logic [DEPTH-1:0]      sel;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] above;
      logic [DATA_WIDTH-1:0] below;

      if (i == 0) begin : g_top
         assign above = push_word;
      end else begin : g_mid
         assign above = words[i-1];
      end

      if (i == DEPTH - 1) begin : g_bot
         assign below = '0;
      end else begin : g_inner
         assign below = words[i+1];
      end

      // depth i+1 matches the requested position
      assign sel[i] = (32'(peek_pos) == 32'(i + 1));

      bas_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .above_word (above),
         .below_word (below),
         .select     (sel[i]),
         .word       (words[i]),
         .tap_word   (taps[i])
      );
   end

   // at most one cell is selected; merge the gated taps
   always_comb begin
      peek_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         peek_word = peek_word | taps[i];
      end
   end

   assign top_word = words[0];

endmodule

[rtl/core/bounded_array_stack.sv]
// ----------------------------------------------------------------------------
// bounded_array_stack: LIFO stack of signed words with a capacity register
// Push, pop, peek, read top and drain over a row of shifting cells.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  opcode, push_value, peek_position
//   rsp_      out        rsp_valid / rsp_stall  data, status, is_empty, is_full,
//                                               entry_total, last
//   csr_      in/out     psel, penable, pready  capacity at byte address 0
//
// Push, pop, peek and read top each load the result register when taken:
// a request is taken in any cycle in which the result register is free
// or being emptied. Drain of N entries pops the cell row once per entry,
// one pop per cycle unless the result stalls; requests stall until the
// last word is in the result register. A stalled result holds the whole block.
// Reset clears the entry count, the drain flag and the result valid and
// restores capacity to 64; the cells themselves are not cleared.
// ----------------------------------------------------------------------------
module bounded_array_stack #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bas_pkg::OP_W-1:0]        req_opcode,
   input  logic signed [bas_pkg::WORD_W-1:0] req_push_value,
   input  logic [bas_pkg::POS_W-1:0]       req_peek_position,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [bas_pkg::WORD_W-1:0] rsp_data,
   output logic [bas_pkg::ST_W-1:0]        rsp_status,
   output logic                            rsp_is_empty,
   output logic                            rsp_is_full,
   output logic [bas_pkg::TOT_W-1:0]       rsp_entry_total,
   output logic                            rsp_last,

   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bas_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bas_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bas_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import bas_pkg::*;

   // count width holds DEPTH itself; comparisons run at the wider of the
   // count and the 7-bit capacity / position fields
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WIDE_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [WIDE_W-1:0] DEPTH_W = WIDE_W'(DEPTH);

   // ------------------------------------------------------------------
   // configuration register
   // ------------------------------------------------------------------
   logic [CAP_W-1:0] cap_ff;
   logic [CAP_W-1:0] cap_in;
   logic             csr_write;
   logic             csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == REG_CAPACITY);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cap_in = cap_ff;
      if (csr_write && csr_hit) begin
         cap_in = csr_pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   assign csr_prdata = csr_hit ? CSR_DATA_W'(cap_ff) : '0;

   // clamp capacity to 1..DEPTH
   logic [WIDE_W-1:0] cap_wide;
   logic [WIDE_W-1:0] eff_cap;

   assign cap_wide = WIDE_W'(cap_ff);

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = WIDE_W'(1);
      end else if (cap_wide > DEPTH_W) begin
         eff_cap = DEPTH_W;
      end else begin
         eff_cap = cap_wide;
      end
   end

   // ------------------------------------------------------------------
   // control state
   // ------------------------------------------------------------------
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             drain_ff;
   logic             drain_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic [ST_W-1:0]  rsp_status_ff, rsp_status_in;
   logic             rsp_empty_ff, rsp_empty_in;
   logic             rsp_full_ff, rsp_full_in;
   logic [TOT_W-1:0] rsp_total_ff, rsp_total_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             advance;     // result register free or being taken
   logic             req_take;
   logic             emit;
   shift_type        shift;

   logic [DATA_WIDTH-1:0] push_word;
   logic [DATA_WIDTH-1:0] top_word;
   logic [DATA_WIDTH-1:0] peek_word;

   logic [WIDE_W-1:0] count_wide;
   logic [WIDE_W-1:0] pos_wide;
   logic              is_empty_now;
   logic              is_full_now;
   logic              one_left;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   // hold requests while a drain is still popping or the result is stuck
   assign req_stall = drain_ff || !advance;
   assign req_take  = req_valid && !req_stall;

   // store the low DATA_WIDTH bits of the sign-extended value
   assign push_word = DATA_WIDTH'(req_push_value);

   assign count_wide   = WIDE_W'(count_ff);
   assign pos_wide     = WIDE_W'(req_peek_position);
   assign is_empty_now = (count_ff == '0);
   assign is_full_now  = (count_wide >= eff_cap);
   assign one_left     = (count_ff == CNT_W'(1));

   // ------------------------------------------------------------------
   // next-state and result selection
   // ------------------------------------------------------------------
   always_comb begin
      count_in      = count_ff;
      drain_in      = drain_ff;
      shift         = '0;
      emit          = 1'b0;
      rsp_data_in   = '0;
      rsp_status_in = ST_OK;
      rsp_last_in   = 1'b1;

      if (drain_ff && advance) begin
         // drain in progress: pop the top, mark the final word
         shift.pop   = 1'b1;
         emit        = 1'b1;
         rsp_data_in = WORD_W'(top_word);
         count_in    = count_ff - CNT_W'(1);
         rsp_last_in = one_left;
         drain_in    = !one_left;
      end else if (req_take) begin
         case (req_opcode)
            OP_PUSH: begin
               emit = 1'b1;
               if (is_full_now) begin
                  rsp_status_in = ST_OVERFLOW;
               end else begin
                  shift.push  = 1'b1;
                  rsp_data_in = WORD_W'(push_word);
                  count_in    = count_ff + CNT_W'(1);
               end
            end
            OP_POP: begin
               emit = 1'b1;
               if (is_empty_now) begin
                  rsp_status_in = ST_UNDERFLOW;
               end else begin
                  shift.pop   = 1'b1;
                  rsp_data_in = WORD_W'(top_word);
                  count_in    = count_ff - CNT_W'(1);
               end
            end
            OP_PEEK: begin
               emit = 1'b1;
               if (req_peek_position == '0 || pos_wide > count_wide) begin
                  rsp_status_in = ST_BADPOS;
               end else begin
                  rsp_data_in = WORD_W'(peek_word);
               end
            end
            OP_TOP: begin
               emit = 1'b1;
               if (is_empty_now) begin
                  rsp_status_in = ST_UNDERFLOW;
               end else begin
                  rsp_data_in = WORD_W'(top_word);
               end
            end
            OP_DRAIN: begin
               // empty stack: nothing to emit; otherwise pop the first word now
               if (!is_empty_now) begin
                  shift.pop   = 1'b1;
                  emit        = 1'b1;
                  rsp_data_in = WORD_W'(top_word);
                  count_in    = count_ff - CNT_W'(1);
                  rsp_last_in = one_left;
                  drain_in    = !one_left;
               end
            end
            default: begin
               // unused opcodes: drop the word
            end
         endcase
      end

      // flags describe the stack after this step
      rsp_empty_in = (count_in == '0);
      rsp_full_in  = (WIDE_W'(count_in) >= eff_cap);
      rsp_total_in = TOT_W'(count_in);

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload: load only when a new word goes out
   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_full_ff   <= rsp_full_in;
         rsp_total_ff  <= rsp_total_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = $signed(rsp_data_ff);
   assign rsp_status      = rsp_status_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;
   assign rsp_entry_total = rsp_total_ff;
   assign rsp_last        = rsp_last_ff;

   // ------------------------------------------------------------------
   // cell row
   // ------------------------------------------------------------------
   bas_cell_chain #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_chain (
      .clock     (clock),
      .ctrl      (shift),
      .push_word (push_word),
      .peek_pos  (req_peek_position),
      .top_word  (top_word),
      .peek_word (peek_word)
   );

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_count_bound : assert property (
      @(posedge clock) disable iff (reset)
      WIDE_W'(count_ff) <= DEPTH_W
   ) else $error("entry count beyond depth");

   a_not_last_means_drain : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> drain_ff
   ) else $error("non-final result with no drain pending");

   a_push_counts : assert property (
      @(posedge clock) disable iff (reset)
      (req_take && req_opcode == OP_PUSH && !is_full_now)
         |=> (count_ff == $past(count_ff) + CNT_W'(1))
   ) else $error("accepted push did not grow the stack");

   a_drain_shrinks : assert property (
      @(posedge clock) disable iff (reset)
      (drain_ff && advance) |=> (count_ff == $past(count_ff) - CNT_W'(1))
   ) else $error("drain step did not pop");

endmodule
